>>> hdl/sloa_pkg.sv
// Shared types and constants for the slab allocator with frame collection.
package sloa_pkg;

    // Widths of the item fields
    localparam int OP_W     = 3;
    localparam int INDEX_W  = 12;
    localparam int COUNT_W  = 13;
    localparam int STATUS_W = 2;
    localparam int CTL_W    = 16;

    // Control word layout
    localparam int CTL_MARK_BIT  = 15;
    localparam int CTL_ALLOC_BIT = 14;
    localparam logic [CTL_W-1:0]   CTL_MARK  = 16'h8000;
    localparam logic [CTL_W-1:0]   CTL_ALLOC = 16'h4000;
    localparam logic [COUNT_W-1:0] CTL_FRAME = 13'h1fff;
    localparam logic [CTL_W-1:0]   LIST_END  = 16'hffff & ~CTL_ALLOC;

    // Slot count after reset
    localparam logic [COUNT_W-1:0] OBJ_RESET = 13'd64;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC       = 3'd0,
        OP_FREE        = 3'd1,
        OP_BEGIN_MARK  = 3'd2,
        OP_MARK        = 3'd3,
        OP_ABORT_MARK  = 3'd4,
        OP_SWEEP       = 3'd5,
        OP_SWEEP_POP   = 3'd6,
        OP_PUSH_FRAME  = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_SLOT   = 2'd1,
        ST_NOT_ALLOC = 2'd2
    } status_t;

    typedef struct packed {
        op_t                operation;
        logic [INDEX_W-1:0] target_index;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  granted_index;
        logic                newly_marked;
        logic [COUNT_W-1:0]  freed_count;
    } out_item_t;

    // Operations of the control word unit
    typedef enum logic [2:0] {
        WU_NOP         = 3'd0,
        WU_ALLOC       = 3'd1,
        WU_FREE        = 3'd2,
        WU_MARK        = 3'd3,
        WU_SWEEP       = 3'd4,
        WU_SWEEP_MERGE = 3'd5
    } wu_op_t;

    typedef struct packed {
        logic             wr_en;
        logic [CTL_W-1:0] wr_word;
        logic             newly_marked;
        logic             released;
    } wu_res_t;

endpackage

>>> hdl/sloa_slot_ram.sv
// Control word store: one write port, one registered read port.
module sloa_slot_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [sloa_pkg::CTL_W-1:0] wdata,
    input  logic [AW-1:0]              raddr,
    output logic [sloa_pkg::CTL_W-1:0] rdata
);

    logic [sloa_pkg::CTL_W-1:0] mem [DEPTH];
    logic [sloa_pkg::CTL_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/sloa_word_unit.sv
// Shared control word unit: decides the new word for alloc, free, mark and sweep.
module sloa_word_unit (
    input  logic [sloa_pkg::CTL_W-1:0]   word_in,
    input  sloa_pkg::wu_op_t             op,
    input  logic                         pol,
    input  logic [sloa_pkg::COUNT_W-1:0] frame,
    input  logic [sloa_pkg::CTL_W-1:0]   link_word,
    output sloa_pkg::wu_res_t            res
);

    logic                         is_alloc;
    logic                         unmarked;
    logic                         in_frame;
    logic [sloa_pkg::COUNT_W-1:0] frame_dec;

    assign is_alloc  = word_in[sloa_pkg::CTL_ALLOC_BIT];
    assign unmarked  = word_in[sloa_pkg::CTL_MARK_BIT] != pol;
    assign in_frame  = (word_in[sloa_pkg::COUNT_W-1:0] == frame);
    assign frame_dec = (frame - 13'd1) & sloa_pkg::CTL_FRAME;

    always_comb begin
        res = '0;
        unique case (op)
            sloa_pkg::WU_ALLOC: begin
                res.wr_en   = 1'b1;
                res.wr_word = {pol, 1'b1, 1'b0, frame};
            end
            sloa_pkg::WU_FREE: begin
                if (is_alloc) begin
                    res.wr_en    = 1'b1;
                    res.wr_word  = link_word;
                    res.released = 1'b1;
                end
            end
            sloa_pkg::WU_MARK: begin
                if (is_alloc && unmarked) begin
                    res.wr_en        = 1'b1;
                    res.wr_word      = word_in ^ sloa_pkg::CTL_MARK;
                    res.newly_marked = 1'b1;
                end
            end
            sloa_pkg::WU_SWEEP, sloa_pkg::WU_SWEEP_MERGE: begin
                // unmarked current-frame objects go back on the free list, other unmarked
                // ones get their mark toggled, marked current-frame ones drop a frame on merge
                if (is_alloc) begin
                    if (unmarked && in_frame) begin
                        res.wr_en    = 1'b1;
                        res.wr_word  = link_word;
                        res.released = 1'b1;
                    end else if (unmarked) begin
                        res.wr_en   = 1'b1;
                        res.wr_word = word_in ^ sloa_pkg::CTL_MARK;
                    end else if (in_frame && op == sloa_pkg::WU_SWEEP_MERGE) begin
                        res.wr_en   = 1'b1;
                        res.wr_word = {pol, 1'b1, 1'b0, frame_dec};
                    end
                end
            end
            default: begin
                res = '0;
            end
        endcase
    end

endmodule

>>> hdl/slab_object_allocator_with_frame_gc.sv
// Slab object allocator with mark polarity, frames and sweep sequencer.
//
// Usage: one operation beat enters on s_valid/s_ready (operation, target_index)
// and exactly one result beat leaves on m_valid/m_ready (status, granted_index,
// newly_marked, freed_count). One operation is worked on at a time; s_ready is
// low while it is in progress.
// Path from accept to result on m_valid: S_DECODE and S_RESP for begin mark,
// abort mark, push frame, alloc from an untouched slot, out-of-range free and
// mark, alloc with no slot left and a sweep with nothing to do; S_DECODE, S_RMW
// and S_RESP for alloc from the free list, free and mark (read-modify-write
// over the control store); S_DECODE, S_SWEEP and S_RESP for a sweep that walks
// the effective slots, one control word per cycle going to the shared word unit.
// s_ready returns when the result register is loaded, in the same cycle as m_valid.
// The result sits in an output register: the next operation is accepted while
// it waits, and only the following result stalls if m_ready stays low.
// Reset (aresetn low, synchronous) and every cfg write start a clearing pass over
// all SLOTS words that zeroes the control store; s_ready stays low during it.
// cfg_ready is always high; a cfg write sets the slot count and empties the slab.
module slab_object_allocator_with_frame_gc #(
    parameter int SLOTS = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  sloa_pkg::in_item_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output sloa_pkg::out_item_t          m_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [sloa_pkg::COUNT_W-1:0] cfg_wdata
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = sloa_pkg::COUNT_W;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_DECODE = 6'b000100,
        S_RMW    = 6'b001000,
        S_SWEEP  = 6'b010000,
        S_RESP   = 6'b100000
    } fsm_t;

    // Clamp the configured slot count to 1..SLOTS
    function automatic logic [CW-1:0] slot_limit(input logic [CW-1:0] v);
        logic [CW-1:0] r;
        r = v;
        if (v == '0) r = 13'd1;
        if (v > CW'(SLOTS)) r = CW'(SLOTS);
        return r;
    endfunction

    fsm_t                          state_reg, state_next;
    sloa_pkg::op_t                 op_reg, op_next;
    logic [sloa_pkg::INDEX_W-1:0]  idx_reg, idx_next;
    logic [CW-1:0]                 obj_reg, obj_next;
    logic                          head_vld_reg, head_vld_next;
    logic [IDX_W-1:0]              head_idx_reg, head_idx_next;
    logic [CW-1:0]                 avail_reg, avail_next;
    logic                          pol_reg, pol_next;
    logic [CW-1:0]                 frame_reg, frame_next;
    logic                          swept_reg, swept_next;
    logic [IDX_W-1:0]              clr_cnt_reg, clr_cnt_next;
    logic [IDX_W-1:0]              sw_cnt_reg, sw_cnt_next;
    logic                          sw_issue_reg, sw_issue_next;
    logic                          sw_pv_reg, sw_pv_next;
    logic [IDX_W-1:0]              sw_paddr_reg, sw_paddr_next;
    logic [CW-1:0]                 freed_reg, freed_next;
    sloa_pkg::out_item_t           res_reg, res_next;
    logic                          m_valid_reg, m_valid_next;
    sloa_pkg::out_item_t           m_data_reg, m_data_next;

    logic                          mem_we;
    logic [IDX_W-1:0]              mem_waddr;
    logic [sloa_pkg::CTL_W-1:0]    mem_wdata;
    logic [IDX_W-1:0]              mem_raddr;
    logic [sloa_pkg::CTL_W-1:0]    mem_rdata;

    sloa_pkg::wu_op_t              wu_op;
    sloa_pkg::wu_res_t             wu_res;
    logic [sloa_pkg::CTL_W-1:0]    link_word;

    logic [CW-1:0]                 n_eff;
    logic [CW:0]                   fresh_diff;
    logic                          fresh_oob;
    logic                          idx_oob;
    logic [IDX_W-1:0]              idx_lo;

    assign n_eff      = slot_limit(obj_reg);
    assign fresh_diff = {1'b0, n_eff} - {1'b0, avail_reg};
    assign fresh_oob  = fresh_diff >= (CW+1)'(SLOTS);
    assign idx_oob    = {1'b0, idx_reg} >= n_eff;
    assign idx_lo     = idx_reg[IDX_W-1:0];
    assign link_word  = head_vld_reg ? sloa_pkg::CTL_W'(head_idx_reg) : sloa_pkg::LIST_END;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    sloa_slot_ram #(
        .DEPTH (SLOTS),
        .AW    (IDX_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    sloa_word_unit u_word (
        .word_in   (mem_rdata),
        .op        (wu_op),
        .pol       (pol_reg),
        .frame     (frame_reg),
        .link_word (link_word),
        .res       (wu_res)
    );

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        idx_next      = idx_reg;
        obj_next      = obj_reg;
        head_vld_next = head_vld_reg;
        head_idx_next = head_idx_reg;
        avail_next    = avail_reg;
        pol_next      = pol_reg;
        frame_next    = frame_reg;
        swept_next    = swept_reg;
        clr_cnt_next  = clr_cnt_reg;
        sw_cnt_next   = sw_cnt_reg;
        sw_issue_next = sw_issue_reg;
        sw_pv_next    = sw_pv_reg;
        sw_paddr_next = sw_paddr_reg;
        freed_next    = freed_reg;
        res_next      = res_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg;
        mem_we        = 1'b0;
        mem_waddr     = sw_paddr_reg;
        mem_wdata     = wu_res.wr_word;
        mem_raddr     = sw_cnt_reg;
        wu_op         = sloa_pkg::WU_NOP;

        // output register drains independently
        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
                if (clr_cnt_reg == IDX_W'(SLOTS - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_data.operation;
                    idx_next   = s_data.target_index;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                res_next   = '0;
                state_next = S_RESP;
                unique case (op_reg)
                    sloa_pkg::OP_ALLOC: begin
                        if (avail_reg == '0) begin
                            res_next.status = sloa_pkg::ST_NO_SLOT;
                        end else if (head_vld_reg) begin
                            mem_raddr  = head_idx_reg;
                            state_next = S_RMW;
                        end else if (fresh_oob) begin
                            res_next.status = sloa_pkg::ST_NO_SLOT;
                        end else begin
                            // hand out the next untouched slot
                            wu_op     = sloa_pkg::WU_ALLOC;
                            mem_we    = 1'b1;
                            mem_waddr = fresh_diff[IDX_W-1:0];
                            avail_next = avail_reg - 1'b1;
                            res_next.granted_index =
                                sloa_pkg::INDEX_W'(fresh_diff[IDX_W-1:0]);
                        end
                    end
                    sloa_pkg::OP_FREE: begin
                        if (idx_oob) begin
                            res_next.status = sloa_pkg::ST_NOT_ALLOC;
                        end else begin
                            mem_raddr  = idx_lo;
                            state_next = S_RMW;
                        end
                    end
                    sloa_pkg::OP_BEGIN_MARK, sloa_pkg::OP_ABORT_MARK: begin
                        pol_next = ~pol_reg;
                    end
                    sloa_pkg::OP_MARK: begin
                        if (!idx_oob) begin
                            mem_raddr  = idx_lo;
                            state_next = S_RMW;
                        end
                    end
                    sloa_pkg::OP_SWEEP, sloa_pkg::OP_SWEEP_POP: begin
                        if (avail_reg >= n_eff || swept_reg == pol_reg) begin
                            if (op_reg == sloa_pkg::OP_SWEEP_POP) begin
                                frame_next = (frame_reg - 1'b1) & sloa_pkg::CTL_FRAME;
                            end
                        end else begin
                            swept_next    = pol_reg;
                            sw_cnt_next   = IDX_W'(n_eff - 1'b1);
                            sw_issue_next = 1'b1;
                            sw_pv_next    = 1'b0;
                            freed_next    = '0;
                            state_next    = S_SWEEP;
                        end
                    end
                    sloa_pkg::OP_PUSH_FRAME: begin
                        frame_next = (frame_reg + 1'b1) & sloa_pkg::CTL_FRAME;
                    end
                    default: begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_RMW: begin
                state_next = S_RESP;
                case (op_reg)
                    sloa_pkg::OP_ALLOC: begin
                        // pop the free-list head, follow its link
                        wu_op      = sloa_pkg::WU_ALLOC;
                        mem_we     = 1'b1;
                        mem_waddr  = head_idx_reg;
                        avail_next = avail_reg - 1'b1;
                        res_next.granted_index = sloa_pkg::INDEX_W'(head_idx_reg);
                        if (mem_rdata < sloa_pkg::CTL_W'(SLOTS)) begin
                            head_vld_next = 1'b1;
                            head_idx_next = mem_rdata[IDX_W-1:0];
                        end else begin
                            head_vld_next = 1'b0;
                        end
                    end
                    sloa_pkg::OP_FREE: begin
                        wu_op     = sloa_pkg::WU_FREE;
                        mem_we    = wu_res.wr_en;
                        mem_waddr = idx_lo;
                        if (wu_res.released) begin
                            head_vld_next = 1'b1;
                            head_idx_next = idx_lo;
                            avail_next    = avail_reg + 1'b1;
                        end else begin
                            res_next.status = sloa_pkg::ST_NOT_ALLOC;
                        end
                    end
                    sloa_pkg::OP_MARK: begin
                        wu_op     = sloa_pkg::WU_MARK;
                        mem_we    = wu_res.wr_en;
                        mem_waddr = idx_lo;
                        res_next.newly_marked = wu_res.newly_marked;
                    end
                    default: begin
                        wu_op = sloa_pkg::WU_NOP;
                    end
                endcase
            end
            S_SWEEP: begin
                // read slot k while the word of slot k+1 is processed
                wu_op = (op_reg == sloa_pkg::OP_SWEEP_POP) ? sloa_pkg::WU_SWEEP_MERGE
                                                          : sloa_pkg::WU_SWEEP;
                mem_raddr  = sw_cnt_reg;
                sw_pv_next = sw_issue_reg;
                if (sw_issue_reg) begin
                    sw_paddr_next = sw_cnt_reg;
                    if (sw_cnt_reg == '0) begin
                        sw_issue_next = 1'b0;
                    end else begin
                        sw_cnt_next = sw_cnt_reg - 1'b1;
                    end
                end
                if (sw_pv_reg) begin
                    mem_we    = wu_res.wr_en;
                    mem_waddr = sw_paddr_reg;
                    if (wu_res.released) begin
                        head_vld_next = 1'b1;
                        head_idx_next = sw_paddr_reg;
                        avail_next    = avail_reg + 1'b1;
                        freed_next    = freed_reg + 1'b1;
                    end
                end
                if (!sw_issue_reg && !sw_pv_reg) begin
                    res_next.freed_count = freed_reg;
                    if (op_reg == sloa_pkg::OP_SWEEP_POP) begin
                        frame_next = (frame_reg - 1'b1) & sloa_pkg::CTL_FRAME;
                    end
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase

        // register write empties the slab and restarts the clearing pass
        if (cfg_valid) begin
            obj_next      = cfg_wdata;
            head_vld_next = 1'b0;
            avail_next    = slot_limit(cfg_wdata);
            swept_next    = 1'b0;
            clr_cnt_next  = '0;
            state_next    = S_CLEAR;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            obj_reg      <= sloa_pkg::OBJ_RESET;
            head_vld_reg <= 1'b0;
            avail_reg    <= slot_limit(sloa_pkg::OBJ_RESET);
            pol_reg      <= 1'b0;
            frame_reg    <= '0;
            swept_reg    <= 1'b0;
            clr_cnt_reg  <= '0;
            sw_issue_reg <= 1'b0;
            sw_pv_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            obj_reg      <= obj_next;
            head_vld_reg <= head_vld_next;
            avail_reg    <= avail_next;
            pol_reg      <= pol_next;
            frame_reg    <= frame_next;
            swept_reg    <= swept_next;
            clr_cnt_reg  <= clr_cnt_next;
            sw_issue_reg <= sw_issue_next;
            sw_pv_reg    <= sw_pv_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        head_idx_reg <= head_idx_next;
        sw_cnt_reg   <= sw_cnt_next;
        sw_paddr_reg <= sw_paddr_next;
        freed_reg    <= freed_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

`ifndef SYNTH
    // an accepted beat always takes the block busy
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("s_ready still high after accept");

    // the control store is never written while waiting for an operation
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("control store written while idle");

    // a result beat appears only out of the response state
    a_result_from_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_RESP))
        else $error("result beat without response state");

    // a running sweep has already recorded the current polarity
    a_sweep_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SWEEP) |-> (swept_reg == pol_reg))
        else $error("sweep running with stale sweep flag");

    // the freed count never passes the slot count during a sweep
    a_freed_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SWEEP) |-> (freed_reg <= n_eff))
        else $error("sweep freed more slots than exist");
`endif

endmodule

>>> tb/tb.sv
// Self-checking testbench for the slab object allocator with frame collection.
module tb;

    localparam int SLOTS       = 64;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int PICK        = -1;   // let the sender choose the target index
    localparam int PHASE_OPS   = 75;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    sloa_pkg::in_item_t            s_data;
    logic                          m_valid;
    logic                          m_ready;
    sloa_pkg::out_item_t           m_data;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [sloa_pkg::COUNT_W-1:0]  cfg_wdata;

    slab_object_allocator_with_frame_gc #(.SLOTS(SLOTS)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata)
    );

    // Predicted slab state
    logic [sloa_pkg::CTL_W-1:0]   slot_word [SLOTS];
    logic [sloa_pkg::CTL_W-1:0]   list_head;
    int unsigned                  free_slots;
    logic                         polarity;
    logic                         swept_polarity;
    logic [sloa_pkg::COUNT_W-1:0] cur_frame;
    logic [sloa_pkg::COUNT_W-1:0] slot_setting;

    // Scoreboard and run control
    sloa_pkg::out_item_t outcome_queue [$];
    int                  outstanding;
    int                  quiet_cycles;
    int unsigned         ops_sent;
    int                  mismatches;
    bit                  steady;
    bit                  hold_req;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Effective slot count: zero reads as one, oversize clamps to the built depth
    function automatic int unsigned usable_slots();
        if (slot_setting == '0) return 1;
        if (slot_setting > SLOTS) return SLOTS;
        return slot_setting;
    endfunction

    // Empty the slab; polarity and frame survive
    function automatic void clear_slab();
        for (int i = 0; i < SLOTS; i++) slot_word[i] = '0;
        list_head      = sloa_pkg::LIST_END;
        free_slots     = usable_slots();
        swept_polarity = 1'b0;
    endfunction

    function automatic void push_free_slot(int unsigned idx);
        slot_word[idx] = list_head;
        list_head      = sloa_pkg::CTL_W'(idx);
        free_slots     = free_slots + 1;
    endfunction

    // Control word of a live object: mark, allocated, spare bit, frame
    function automatic logic [sloa_pkg::CTL_W-1:0] live_word(
        logic [sloa_pkg::COUNT_W-1:0] frm);
        return {polarity, 1'b1, 1'b0, frm};
    endfunction

    // Walk the slab from the top, free unmarked current-frame objects, toggle other unmarked marks, merge on pop
    function automatic logic [sloa_pkg::COUNT_W-1:0] sweep_slab(bit merge);
        int unsigned                  n;
        logic [sloa_pkg::COUNT_W-1:0] freed;
        logic [sloa_pkg::CTL_W-1:0]   w;
        logic                         unmarked;
        n     = usable_slots();
        freed = '0;
        if (free_slots >= n || swept_polarity == polarity) return '0;
        swept_polarity = polarity;
        for (int i = int'(n) - 1; i >= 0; i--) begin
            w = slot_word[i];
            if (!w[sloa_pkg::CTL_ALLOC_BIT]) continue;
            unmarked = (w[sloa_pkg::CTL_MARK_BIT] != polarity);
            // keep marks consistent for the next collection
            if (unmarked) slot_word[i] = w ^ sloa_pkg::CTL_MARK;
            if (w[sloa_pkg::COUNT_W-1:0] != cur_frame) continue;
            if (unmarked) begin
                push_free_slot(i);
                freed = freed + 1'b1;
            end else if (merge) begin
                slot_word[i] = live_word(cur_frame - 1'b1);
            end
        end
        return freed;
    endfunction

    // Expected result beat of one operation; advances the predicted state
    function automatic sloa_pkg::out_item_t slab_outcome(sloa_pkg::in_item_t item);
        sloa_pkg::out_item_t        res;
        int unsigned                n;
        int unsigned                idx;
        int unsigned                slot;
        logic [sloa_pkg::CTL_W-1:0] link;
        res = '0;
        n   = usable_slots();
        idx = item.target_index;
        case (item.operation)
            sloa_pkg::OP_ALLOC: begin
                if (free_slots == 0) begin
                    res.status = sloa_pkg::ST_NO_SLOT;
                end else begin
                    if (list_head != sloa_pkg::LIST_END && list_head < SLOTS) begin
                        slot      = list_head;
                        link      = slot_word[slot];
                        // a link past the store ends the list
                        list_head = (link < SLOTS) ? link : sloa_pkg::LIST_END;
                    end else begin
                        list_head = sloa_pkg::LIST_END;
                        slot      = n - free_slots;
                    end
                    if (slot >= SLOTS) begin
                        res.status = sloa_pkg::ST_NO_SLOT;
                    end else begin
                        slot_word[slot]   = live_word(cur_frame);
                        free_slots        = free_slots - 1;
                        res.granted_index = sloa_pkg::INDEX_W'(slot);
                    end
                end
            end
            sloa_pkg::OP_FREE: begin
                if (idx >= n) res.status = sloa_pkg::ST_NOT_ALLOC;
                else if (!slot_word[idx][sloa_pkg::CTL_ALLOC_BIT])
                    res.status = sloa_pkg::ST_NOT_ALLOC;
                else push_free_slot(idx);
            end
            sloa_pkg::OP_BEGIN_MARK, sloa_pkg::OP_ABORT_MARK: begin
                polarity = ~polarity;
            end
            sloa_pkg::OP_MARK: begin
                if (idx < n) begin
                    if (slot_word[idx][sloa_pkg::CTL_ALLOC_BIT] &&
                        slot_word[idx][sloa_pkg::CTL_MARK_BIT] != polarity) begin
                        slot_word[idx]   = slot_word[idx] ^ sloa_pkg::CTL_MARK;
                        res.newly_marked = 1'b1;
                    end
                end
            end
            sloa_pkg::OP_SWEEP: begin
                res.freed_count = sweep_slab(1'b0);
            end
            sloa_pkg::OP_SWEEP_POP: begin
                res.freed_count = sweep_slab(1'b1);
                cur_frame       = cur_frame - 1'b1;
            end
            default: begin
                cur_frame = cur_frame + 1'b1;
            end
        endcase
        return res;
    endfunction

    function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Mostly live slots, some free or in-range slots, a few anywhere in the field
    function automatic logic [sloa_pkg::INDEX_W-1:0] pick_index();
        int unsigned n;
        int unsigned r;
        int unsigned start;
        int unsigned i;
        n = usable_slots();
        r = $urandom_range(0, 99);
        if (r < 10) return sloa_pkg::INDEX_W'($urandom_range(0, 4095));
        start = $urandom_range(0, n - 1);
        if (r < 30) return sloa_pkg::INDEX_W'(start);
        for (int k = 0; k < int'(n); k++) begin
            i = (start + k) % n;
            if (slot_word[i][sloa_pkg::CTL_ALLOC_BIT]) return sloa_pkg::INDEX_W'(i);
        end
        return sloa_pkg::INDEX_W'(start);
    endfunction

    // Monitor: predict on each accepted operation beat, check each result beat
    always @(posedge aclk) begin
        sloa_pkg::out_item_t want;
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                slot_setting = cfg_wdata;
                clear_slab();
            end
            if (s_valid && s_ready) begin
                outcome_queue.push_back(slab_outcome(s_data));
                outstanding++;
            end
            if (m_valid && m_ready) begin
                if (outcome_queue.size() == 0) begin
                    $error("result beat with no operation pending");
                    mismatches++;
                end else begin
                    want = outcome_queue.pop_front();
                    outstanding--;
                    compare_field("status", want.status, m_data.status);
                    compare_field("granted_index", want.granted_index, m_data.granted_index);
                    compare_field("newly_marked", want.newly_marked, m_data.newly_marked);
                    compare_field("freed_count", want.freed_count, m_data.freed_count);
                end
            end
        end
    end

    // Result side: random stalls, or a long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                m_ready <= steady || ($urandom_range(0, 99) >= 15);
            end
        end
    end

    // Watchdog on cycles without any accepted beat
    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Offer one operation beat and wait until it is accepted
    task automatic send_op(sloa_pkg::op_t op, int idx_req);
        sloa_pkg::in_item_t item;
        int                 gap;
        @(negedge aclk);
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 15) gap = $urandom_range(1, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        item.operation    = op;
        item.target_index = (idx_req == PICK) ? pick_index()
                                              : sloa_pkg::INDEX_W'(idx_req);
        s_data  <= item;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        ops_sent++;
    endtask

    // Stop offering and wait for every pending result
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    task automatic write_slot_count(logic [sloa_pkg::COUNT_W-1:0] value);
        settle();
        cfg_wdata <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // One collection cycle: allocate, mark some, sweep, with some noise
    task automatic gc_round(int unsigned slots_here);
        int unsigned allocs;
        int unsigned marks;
        if ($urandom_range(0, 1)) send_op(sloa_pkg::OP_PUSH_FRAME, PICK);
        allocs = $urandom_range(1, slots_here + 2);
        repeat (allocs) begin
            send_op(sloa_pkg::OP_ALLOC, PICK);
            if ($urandom_range(0, 3) == 0) send_op(sloa_pkg::OP_FREE, PICK);
        end
        send_op(sloa_pkg::OP_BEGIN_MARK, PICK);
        marks = $urandom_range(0, slots_here);
        repeat (marks) send_op(sloa_pkg::OP_MARK, PICK);
        case ($urandom_range(0, 9))
            0: begin
                send_op(sloa_pkg::OP_ABORT_MARK, PICK);
                send_op(sloa_pkg::OP_BEGIN_MARK, PICK);
            end
            1: send_op(sloa_pkg::OP_ABORT_MARK, PICK);
            2: begin
                repeat ($urandom_range(1, 6))
                    send_op(sloa_pkg::op_t'($urandom_range(0, 7)), $urandom_range(0, 4095));
            end
            default: ;
        endcase
        send_op($urandom_range(0, 1) ? sloa_pkg::OP_SWEEP : sloa_pkg::OP_SWEEP_POP, PICK);
    endtask

    task automatic run_phase(logic [sloa_pkg::COUNT_W-1:0] setting, int unsigned ops);
        int unsigned eff;
        int unsigned stop;
        write_slot_count(setting);
        eff  = (setting == '0) ? 1 : ((setting > SLOTS) ? SLOTS : setting);
        stop = ops_sent + ops;
        while (ops_sent < stop) gc_round(eff);
    endtask

    // Every operation at the reset slot count, index extremes, repeat sweep, frame wrap
    task automatic test_directed();
        send_op(sloa_pkg::OP_ALLOC, 0);
        send_op(sloa_pkg::OP_ALLOC, 4095);
        send_op(sloa_pkg::OP_ALLOC, 0);
        send_op(sloa_pkg::OP_FREE, 1);
        send_op(sloa_pkg::OP_FREE, 1);          // double free
        send_op(sloa_pkg::OP_FREE, 4095);       // past the slab
        send_op(sloa_pkg::OP_ALLOC, 0);         // from the free list, then list end
        send_op(sloa_pkg::OP_MARK, 0);          // already reads as marked
        send_op(sloa_pkg::OP_BEGIN_MARK, 0);
        send_op(sloa_pkg::OP_MARK, 0);
        send_op(sloa_pkg::OP_MARK, 0);
        send_op(sloa_pkg::OP_MARK, 4095);
        send_op(sloa_pkg::OP_MARK, 63);         // never allocated
        send_op(sloa_pkg::OP_SWEEP, 0);
        send_op(sloa_pkg::OP_SWEEP, 0);         // already swept for this polarity
        send_op(sloa_pkg::OP_PUSH_FRAME, 0);
        send_op(sloa_pkg::OP_ALLOC, 0);
        send_op(sloa_pkg::OP_BEGIN_MARK, 0);
        send_op(sloa_pkg::OP_ABORT_MARK, 0);
        send_op(sloa_pkg::OP_SWEEP_POP, 0);
        send_op(sloa_pkg::OP_SWEEP_POP, 0);     // frame wraps below zero
        send_op(sloa_pkg::OP_PUSH_FRAME, 4095); // and back up
        send_op(sloa_pkg::OP_FREE, 0);
    endtask

    // Zero and one slot: exhaustion, reuse, sweep of an empty slab
    task automatic test_tiny_slab();
        write_slot_count(13'd0);
        send_op(sloa_pkg::OP_ALLOC, 0);
        send_op(sloa_pkg::OP_ALLOC, 0);
        send_op(sloa_pkg::OP_FREE, 0);
        send_op(sloa_pkg::OP_ALLOC, 0);
        write_slot_count(13'd1);
        send_op(sloa_pkg::OP_BEGIN_MARK, 0);
        send_op(sloa_pkg::OP_SWEEP_POP, 0);
        send_op(sloa_pkg::OP_PUSH_FRAME, 0);
    endtask

    // Result side holds off while operations keep coming, so the input stalls
    task automatic test_backpressure();
        write_slot_count(13'd64);
        hold_req = 1'b1;
        gc_round(SLOTS);
        settle();
    endtask

    task automatic test_random_phases();
        logic [sloa_pkg::COUNT_W-1:0] settings [10];
        settings = '{13'd64, 13'd1, 13'd2, 13'd7, 13'd33, 13'd4096, 13'd8191,
                     13'd0, 13'd63, 13'd20};
        foreach (settings[i]) run_phase(settings[i], PHASE_OPS);
    endtask

    // Long stretch with neither side idling
    task automatic test_steady_stretch();
        steady = 1'b1;
        run_phase(13'd40, 150);
        steady = 1'b0;
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        m_ready      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_wdata    = '0;
        steady       = 1'b0;
        hold_req     = 1'b0;
        outstanding  = 0;
        quiet_cycles = 0;
        ops_sent     = 0;
        mismatches   = 0;
        // predicted state after reset
        slot_setting = sloa_pkg::OBJ_RESET;
        polarity     = 1'b0;
        cur_frame    = '0;
        clear_slab();
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_tiny_slab();
        test_backpressure();
        test_random_phases();
        test_steady_stretch();

        settle();
        repeat (100) @(posedge aclk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> slab_object_allocator_with_frame_gc.f
hdl/sloa_pkg.sv
hdl/sloa_slot_ram.sv
hdl/sloa_word_unit.sv
hdl/slab_object_allocator_with_frame_gc.sv
tb/tb.sv
